/* hw/rtl/hbp_pkg.sv */
package hbp_pkg;

    localparam int MAX_CODE_LEN = 32;
    localparam int SYMBOL_COUNT = 256;
    localparam int LEN_LIMIT    = (MAX_CODE_LEN < 32) ? MAX_CODE_LEN : 32;

    localparam int SYM_W  = 8;
    localparam int CODE_W = 32;
    localparam int LEN_W  = 6;
    localparam int PEND_W = 7;
    localparam int PCNT_W = 3;
    localparam int BYTE_W = 8;
    localparam int CNT_W  = 32;
    localparam int ACC_W  = PEND_W + CODE_W;
    localparam int TOT_W  = 6;
    localparam int ADDR_W = $clog2(SYMBOL_COUNT);

    localparam logic [1:0] ACT_LOAD   = 2'd0;
    localparam logic [1:0] ACT_ENCODE = 2'd1;
    localparam logic [1:0] ACT_FLUSH  = 2'd2;

    typedef struct packed {
        logic [1:0]        action;
        logic [SYM_W-1:0]  symbol;
        logic [CODE_W-1:0] entry_code;
        logic [LEN_W-1:0]  entry_length;
    } hbp_in_t;

    typedef struct packed {
        logic [BYTE_W-1:0] out_byte;
        logic              last_of_run;
        logic [CNT_W-1:0]  bytes_so_far;
    } hbp_out_t;

    typedef struct packed {
        logic [LEN_W-1:0]  len;
        logic [CODE_W-1:0] code;
    } entry_t;

    localparam int ENTRY_W = $bits(entry_t);

    typedef struct packed {
        logic capture;
        logic exec;
        logic emit;
        logic finish;
    } dp_cmd_t;

    typedef struct packed {
        logic has_byte;
        logic out_free;
    } dp_status_t;

endpackage

/* hw/rtl/huffman_bit_packer.sv */
// Huffman encoder, MSB first, with a loadable 256-entry code table. Items are
// taken one at a time: each passes through a capture step (table read issued),
// a merge step and an emit phase that sends one byte per cycle through a single
// output register, then a step that stores the leftover bits. An item yields
// 0 to 4 bytes; backpressure on the output stretches the emit phase. The table is
// valid after reset with no clearing pass: per-entry valid bits, cleared by
// reset, make unwritten entries read as zero length.
module huffman_bit_packer (
    input  logic              aclk,
    input  logic              aresetn,
    input  logic              s_valid,
    output logic              s_ready,
    input  hbp_pkg::hbp_in_t  s_data,
    output logic              m_valid,
    input  logic              m_ready,
    output hbp_pkg::hbp_out_t m_data
);
    import hbp_pkg::*;

    dp_cmd_t    cmd;
    dp_status_t status;

    hbp_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    hbp_datapath u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_data  (s_data),
        .cmd     (cmd),
        .status  (status),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

/* hw/rtl/hbp_ram.sv */
module hbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_reg[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data_reg <= mem_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

/* hw/rtl/hbp_ctrl.sv */
module hbp_ctrl (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  hbp_pkg::dp_status_t status,
    output hbp_pkg::dp_cmd_t    cmd
);
    import hbp_pkg::*;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic   ready_reg, ready_next;

    always_comb begin
        cmd         = '0;
        state_next  = state_reg;
        ready_next  = ready_reg;
        cmd.capture = s_valid && ready_reg;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid && ready_reg) begin
                    state_next = ST_EXEC;
                    ready_next = 1'b0;
                end
            end
            ST_EXEC: begin
                cmd.exec   = 1'b1;
                state_next = ST_EMIT;
            end
            ST_EMIT: begin
                if (status.has_byte) begin
                    cmd.emit = status.out_free;
                end else begin
                    cmd.finish = 1'b1;
                    state_next = ST_IDLE;
                    ready_next = 1'b1;
                end
            end
            default: begin
                state_next = ST_IDLE;
                ready_next = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            ready_reg <= 1'b1;
        end else begin
            state_reg <= state_next;
            ready_reg <= ready_next;
        end
    end

    assign s_ready = ready_reg;

endmodule

/* hw/rtl/hbp_datapath.sv */
module hbp_datapath (
    input  logic                aclk,
    input  logic                aresetn,
    input  hbp_pkg::hbp_in_t    s_data,
    input  hbp_pkg::dp_cmd_t    cmd,
    output hbp_pkg::dp_status_t status,
    output logic                m_valid,
    input  logic                m_ready,
    output hbp_pkg::hbp_out_t   m_data
);
    import hbp_pkg::*;

    // table storage; valid bits make unwritten entries read as zero
    logic                    wr_en;
    logic                    rd_en;
    logic                    in_range;
    entry_t                  wr_entry;
    logic [ENTRY_W-1:0]      rd_word;
    logic [SYMBOL_COUNT-1:0] valid_reg;
    logic                    valid_rd_reg;
    logic                    in_range_reg;
    hbp_in_t                 item_reg;

    logic [ACC_W-1:0]  acc_reg, acc_next;
    logic [TOT_W-1:0]  total_reg, total_next;
    logic [PEND_W-1:0] pend_bits_reg, pend_bits_next;
    logic [PCNT_W-1:0] pend_cnt_reg, pend_cnt_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              m_valid_reg;
    hbp_out_t          m_data_reg;

    entry_t            entry;
    logic              encode_ok;
    logic [LEN_W-1:0]  len_e;
    logic [CODE_W-1:0] code_masked;
    logic [BYTE_W-1:0] flush_byte;
    logic [TOT_W-1:0]  shamt;
    logic [BYTE_W-1:0] mask8;

    assign in_range = {1'b0, s_data.symbol} < (SYM_W + 1)'(SYMBOL_COUNT);
    assign wr_en    = cmd.capture && (s_data.action == ACT_LOAD) && in_range;
    assign rd_en    = cmd.capture;
    assign wr_entry.code = s_data.entry_code;
    assign wr_entry.len  = (s_data.entry_length > LEN_W'(LEN_LIMIT)) ?
                           LEN_W'(LEN_LIMIT) : s_data.entry_length;

    hbp_ram #(
        .WIDTH(ENTRY_W),
        .DEPTH(SYMBOL_COUNT)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (s_data.symbol[ADDR_W-1:0]),
        .wr_data (wr_entry),
        .rd_en   (rd_en),
        .rd_addr (s_data.symbol[ADDR_W-1:0]),
        .rd_data (rd_word)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (wr_en) begin
            valid_reg[s_data.symbol[ADDR_W-1:0]] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.capture) begin
            item_reg     <= s_data;
            in_range_reg <= in_range;
            valid_rd_reg <= valid_reg[s_data.symbol[ADDR_W-1:0]];
        end
    end

    // merge the looked-up code under the pending bits
    always_comb begin
        entry       = valid_rd_reg ? entry_t'(rd_word) : '0;
        encode_ok   = (item_reg.action == ACT_ENCODE) && in_range_reg;
        len_e       = encode_ok ? entry.len : '0;
        code_masked = (len_e == '0) ? '0 :
                      entry.code & ({CODE_W{1'b1}} >> (LEN_W'(CODE_W) - len_e));
        flush_byte  = {1'b0, pend_bits_reg} << (4'(BYTE_W) - {1'b0, pend_cnt_reg});
        shamt       = total_reg - TOT_W'(BYTE_W);
        mask8       = (BYTE_W'(1) << total_reg[PCNT_W-1:0]) - BYTE_W'(1);
    end

    always_comb begin
        acc_next       = acc_reg;
        total_next     = total_reg;
        pend_bits_next = pend_bits_reg;
        pend_cnt_next  = pend_cnt_reg;
        count_next     = count_reg;
        if (cmd.exec) begin
            if (item_reg.action == ACT_FLUSH) begin
                acc_next   = ACC_W'(flush_byte);
                total_next = (pend_cnt_reg != '0) ? TOT_W'(BYTE_W) : '0;
            end else begin
                acc_next   = (ACC_W'(pend_bits_reg) << len_e) | ACC_W'(code_masked);
                total_next = TOT_W'(pend_cnt_reg) + TOT_W'(len_e);
            end
        end
        if (cmd.emit) begin
            total_next = shamt;
            if (count_reg != {CNT_W{1'b1}}) begin
                count_next = count_reg + CNT_W'(1);
            end
        end
        if (cmd.finish) begin
            pend_bits_next = acc_reg[PEND_W-1:0] & mask8[PEND_W-1:0];
            pend_cnt_next  = total_reg[PCNT_W-1:0];
            if (item_reg.action == ACT_FLUSH) begin
                count_next = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_bits_reg <= '0;
            pend_cnt_reg  <= '0;
            count_reg     <= '0;
            total_reg     <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            pend_bits_reg <= pend_bits_next;
            pend_cnt_reg  <= pend_cnt_next;
            count_reg     <= count_next;
            total_reg     <= total_next;
            if (cmd.emit) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        acc_reg <= acc_next;
        if (cmd.emit) begin
            m_data_reg.out_byte     <= BYTE_W'(acc_reg >> shamt);
            m_data_reg.last_of_run  <= (shamt < TOT_W'(BYTE_W));
            m_data_reg.bytes_so_far <= count_next;
        end
    end

    assign status.has_byte = (total_reg >= TOT_W'(BYTE_W));
    assign status.out_free = !m_valid_reg || m_ready;
    assign m_valid         = m_valid_reg;
    assign m_data          = m_data_reg;

endmodule

/* tb/tb_huffman_bit_packer.sv */
`timescale 1ns / 100ps

module tb_huffman_bit_packer;

    import hbp_pkg::*;

    localparam logic [1:0] ACT_SPARE   = 2'd3;
    localparam int         CYCLE_LIMIT = 200000;
    localparam int         RAND_ITEMS  = 231;

    logic     aclk    = 1'b0;
    logic     aresetn = 1'b0;
    logic     s_valid = 1'b0;
    logic     s_ready;
    hbp_in_t  s_data  = '0;
    logic     m_valid;
    logic     m_ready = 1'b0;
    hbp_out_t m_data;

    huffman_bit_packer u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // predictor state
    logic [CODE_W-1:0] tbl_code [SYMBOL_COUNT];
    logic [LEN_W-1:0]  tbl_len  [SYMBOL_COUNT];
    logic [PEND_W-1:0] pend_bits = '0;
    logic [PCNT_W-1:0] pend_cnt  = '0;
    logic [CNT_W-1:0]  byte_cnt  = '0;
    hbp_out_t          byte_q [$];

    int unsigned errors      = 0;
    int unsigned items_sent  = 0;
    int unsigned bytes_seen  = 0;
    int unsigned flush_count = 0;
    int unsigned cycles      = 0;
    int unsigned stall_left  = 0;
    bit          idle_on     = 1'b1;

    initial begin
        for (int i = 0; i < SYMBOL_COUNT; i++) begin
            tbl_code[i] = '0;
            tbl_len[i]  = '0;
        end
    end

    function automatic int unsigned pick_gap();
        int unsigned r;
        r = $urandom_range(0, 99);
        if (!idle_on || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(5, 20);
    endfunction

    function automatic void count_byte();
        if (byte_cnt != '1)
            byte_cnt = byte_cnt + 1'b1;
    endfunction

    // expected bytes for one accepted transaction
    function automatic void pack_item(hbp_in_t it);
        logic [63:0] acc;
        int unsigned len;
        int unsigned total;
        int          n;
        hbp_out_t    r;
        case (it.action)
            ACT_LOAD: begin
                if (it.symbol < SYMBOL_COUNT) begin
                    len = 32'(it.entry_length);
                    if (len > LEN_LIMIT)
                        len = LEN_LIMIT;
                    tbl_code[it.symbol] = it.entry_code;
                    tbl_len[it.symbol]  = LEN_W'(len);
                end
            end
            ACT_ENCODE: begin
                len = (it.symbol < SYMBOL_COUNT) ? 32'(tbl_len[it.symbol]) : 0;
                if (len != 0) begin
                    acc = (64'(pend_bits) << len)
                        | (64'(tbl_code[it.symbol]) & ((64'd1 << len) - 64'd1));
                    total = pend_cnt + len;
                    n = 0;
                    while (total >= 8 && n < 4) begin
                        count_byte();
                        r.out_byte     = 8'(acc >> (total - 8));
                        r.last_of_run  = (total - 8 < 8) || (n == 3);
                        r.bytes_so_far = byte_cnt;
                        byte_q.push_back(r);
                        n++;
                        total -= 8;
                    end
                    pend_bits = PEND_W'(acc & ((64'd1 << total) - 64'd1));
                    pend_cnt  = PCNT_W'(total);
                end
            end
            ACT_FLUSH: begin
                if (pend_cnt != 0) begin
                    count_byte();
                    r.out_byte     = 8'({1'b0, pend_bits} << (8 - pend_cnt));
                    r.last_of_run  = 1'b1;
                    r.bytes_so_far = byte_cnt;
                    byte_q.push_back(r);
                end
                pend_bits = '0;
                pend_cnt  = '0;
                byte_cnt  = '0;
                flush_count++;
            end
            default: ;
        endcase
    endfunction

    task automatic send_item(input logic [1:0] act, input logic [SYM_W-1:0] sym,
                             input logic [CODE_W-1:0] code, input logic [LEN_W-1:0] len);
        hbp_in_t     it;
        int unsigned gap;
        it.action       = act;
        it.symbol       = sym;
        it.entry_code   = code;
        it.entry_length = len;
        gap = pick_gap();
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do @(posedge aclk); while (!s_ready);
        pack_item(it);
        items_sent++;
    endtask

    // result side: random stalls
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (stall_left > 0) begin
            m_ready <= 1'b0;
            stall_left--;
        end else begin
            m_ready <= 1'b1;
            stall_left = pick_gap();
        end
    end

    hbp_out_t want;

    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready) begin
            bytes_seen++;
            if (byte_q.size() == 0) begin
                errors++;
                $display("%0t: unexpected transaction, got byte %h last %b count %0d",
                         $time, m_data.out_byte, m_data.last_of_run, m_data.bytes_so_far);
            end else begin
                want = byte_q.pop_front();
                if (m_data.out_byte !== want.out_byte) begin
                    errors++;
                    $display("%0t: out_byte expected %h actual %h",
                             $time, want.out_byte, m_data.out_byte);
                end
                if (m_data.last_of_run !== want.last_of_run) begin
                    errors++;
                    $display("%0t: last_of_run expected %b actual %b",
                             $time, want.last_of_run, m_data.last_of_run);
                end
                if (m_data.bytes_so_far !== want.bytes_so_far) begin
                    errors++;
                    $display("%0t: bytes_so_far expected %0d actual %0d",
                             $time, want.bytes_so_far, m_data.bytes_so_far);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("%0t: timeout with %0d bytes still expected", $time, byte_q.size());
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    // cleared table: nothing comes out; also empty flush and the spare action
    task automatic test_empty_table();
        send_item(ACT_ENCODE, 8'd0, 32'hFFFF_FFFF, 6'd63);
        send_item(ACT_ENCODE, 8'd255, 32'h0, 6'd0);
        send_item(ACT_FLUSH, 8'd0, 32'h0, 6'd0);
        send_item(ACT_SPARE, 8'hFF, 32'hFFFF_FFFF, 6'h3F);
    endtask

    // length extremes, capping, masked upper code bits, zero length
    task automatic test_lengths();
        send_item(ACT_LOAD, 8'd0, 32'hFFFF_FFFF, 6'd1);
        send_item(ACT_LOAD, 8'd255, 32'hA5A5_A5A5, 6'd32);
        send_item(ACT_LOAD, 8'd128, 32'h0000_0001, 6'd63);
        send_item(ACT_LOAD, 8'd1, 32'hFFFF_FF00, 6'd0);
        send_item(ACT_LOAD, 8'd2, 32'hFFFF_FFF5, 6'd3);
        send_item(ACT_LOAD, 8'd3, 32'h0000_00C3, 6'd8);
        send_item(ACT_ENCODE, 8'd0, 32'h0, 6'd0);
        send_item(ACT_ENCODE, 8'd255, 32'h0, 6'd0);
        send_item(ACT_ENCODE, 8'd1, 32'h0, 6'd0);
        send_item(ACT_ENCODE, 8'd128, 32'h0, 6'd0);
        send_item(ACT_ENCODE, 8'd2, 32'h0, 6'd0);
        send_item(ACT_ENCODE, 8'd3, 32'h0, 6'd0);
    endtask

    // partial byte padding, and 7 pending bits plus a 32-bit code
    task automatic test_flush_padding();
        send_item(ACT_FLUSH, 8'd0, 32'h0, 6'd0);
        for (int i = 0; i < 7; i++)
            send_item(ACT_ENCODE, 8'd0, 32'h0, 6'd0);
        send_item(ACT_ENCODE, 8'd255, 32'h0, 6'd0);
        send_item(ACT_FLUSH, 8'd0, 32'h0, 6'd0);
        send_item(ACT_ENCODE, 8'd3, 32'h0, 6'd0);
        send_item(ACT_FLUSH, 8'd0, 32'h0, 6'd0);
    endtask

    task automatic test_random_stream();
        logic [SYM_W-1:0] live_syms [$];
        logic [SYM_W-1:0] sym;
        logic [LEN_W-1:0] len;
        int unsigned      r;
        for (int i = 0; i < RAND_ITEMS; i++) begin
            if (i % 40 == 0)
                idle_on = ($urandom_range(0, 3) != 0);
            r   = $urandom_range(0, 99);
            sym = SYM_W'($urandom_range(0, 255));
            r   = (i < 20) ? 0 : r;
            if (r < 8) begin
                case ($urandom_range(0, 9))
                    0, 1, 2, 3, 4: len = LEN_W'($urandom_range(1, 8));
                    5, 6:          len = LEN_W'($urandom_range(9, 16));
                    7:             len = LEN_W'($urandom_range(17, 32));
                    8:             len = LEN_W'($urandom_range(33, 63));
                    default:       len = 6'd0;
                endcase
                send_item(ACT_LOAD, sym, $urandom, len);
                if (len != 0)
                    live_syms.push_back(sym);
            end else if (r < 88 && live_syms.size() != 0) begin
                send_item(ACT_ENCODE, live_syms[$urandom_range(0, live_syms.size() - 1)],
                          $urandom, LEN_W'($urandom_range(0, 63)));
            end else if (r < 93) begin
                send_item(ACT_FLUSH, sym, $urandom, LEN_W'($urandom_range(0, 63)));
            end else if (r < 97) begin
                send_item(ACT_ENCODE, sym, $urandom, LEN_W'($urandom_range(0, 63)));
            end else begin
                send_item(ACT_SPARE, sym, $urandom, LEN_W'($urandom_range(0, 63)));
            end
        end
        idle_on = 1'b1;
        send_item(ACT_FLUSH, 8'd0, 32'h0, 6'd0);
    endtask

    initial begin
        repeat (6) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_empty_table();
        test_lengths();
        test_flush_padding();
        test_random_stream();

        s_valid <= 1'b0;
        while (byte_q.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("Sent %0d transactions (%0d flushes), checked %0d output bytes.",
                 items_sent, flush_count, bytes_seen);
        $display("Covered length extremes, capping, masked codes, padding and stalls.");
        if (errors == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
